// File: src/msjf_pkg.sv
// ----------------------------------------------------------------------------
// msjf_pkg: shared types and constants of the multilevel SJF scheduler
// Sizes, job entry layout, memory request bundle and controller states.
// ----------------------------------------------------------------------------
package msjf_pkg;

  localparam int LEVELS = 4;
  localparam int DEPTH  = 4;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(LEVELS * DEPTH);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  typedef logic [LW-1:0] lvl_t;
  typedef logic [PW-1:0] slot_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    lvl_t   rd_lvl;
    slot_t  rd_slot;
    logic   wr_en;
    lvl_t   wr_lvl;
    slot_t  wr_slot;
    entry_t wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS,
    S_FIN,
    S_TAKE
  } state_e;

  // physical slot of queue position pos in a ring that starts at head
  function automatic slot_t slot_add(slot_t head, slot_t pos);
    logic [PW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic slot_t slot_inc(slot_t s);
    return (s == PW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

// File: src/msjf_store.sv
// ----------------------------------------------------------------------------
// msjf_store: job entry memory
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module msjf_store (
  input  logic               clk_i,
  input  msjf_pkg::mem_req_t req_i,
  output msjf_pkg::entry_t   rd_data_o
);
  import msjf_pkg::*;

  entry_t mem_q [LEVELS*DEPTH];
  entry_t rd_data_q;
  addr_t  rd_addr;
  addr_t  wr_addr;

  assign rd_addr = AW'(req_i.rd_lvl) * AW'(DEPTH) + AW'(req_i.rd_slot);
  assign wr_addr = AW'(req_i.wr_lvl) * AW'(DEPTH) + AW'(req_i.wr_slot);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/msjf_pick.sv
// ----------------------------------------------------------------------------
// msjf_pick: level selection for a take
// Finds the lowest-numbered level with a nonzero count.
// ----------------------------------------------------------------------------
module msjf_pick (
  input  msjf_pkg::cnt_t cnt_i [msjf_pkg::LEVELS],
  output logic           found_o,
  output msjf_pkg::lvl_t lvl_o
);
  import msjf_pkg::*;

  always_comb begin
    found_o = 1'b0;
    lvl_o   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_i[l] != '0) begin
        found_o = 1'b1;
        lvl_o   = LW'(l);
      end
    end
  end

endmodule

// File: src/multilevel_sjf_scheduler.sv
// Steps: a take reads the head of the lowest nonempty level in S_START and loads
//   it in S_TAKE, or loads a refusal in S_START if none waits. A refused insert,
//   or one into an empty level, is settled in S_START; otherwise S_INS moves each
//   longer entry up one slot from the tail, then the job is written in S_INS or S_FIN.
// Throughput: one request at a time; the next request is taken once the result
//   is in the output register, and a result that waits holds the scheduler back.
// Reset: level counts and ring heads clear; the job memory is not cleared.
// ----------------------------------------------------------------------------
// multilevel_sjf_scheduler: four-level shortest-job-first scheduler
// Each level is a ring in memory kept sorted by burst; insert walks from the
// tail, take serves the head of the lowest nonempty level.
// ----------------------------------------------------------------------------
module multilevel_sjf_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [0:0]  opcode_i,
  input  logic [1:0]  level_i,
  input  logic [7:0]  job_id_i,
  input  logic [15:0] burst_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [7:0]  served_id_o,
  output logic [15:0] served_burst_o,
  output logic [1:0]  served_level_o
);
  import msjf_pkg::*;

  state_e   state_q, state_d;
  logic     op_q;
  lvl_t     lvl_q;
  logic     lvl_ok_q;
  entry_t   new_q;
  slot_t    k_q;
  cnt_t     cnt_q  [LEVELS];
  slot_t    head_q [LEVELS];

  logic     out_valid_q;
  logic     acc_q;
  logic [7:0]  sid_q;
  logic [15:0] sb_q;
  logic [1:0]  slv_q;

  mem_req_t mreq;
  entry_t   rdata;
  logic     pick_found;
  lvl_t     pick_lvl;

  logic     out_free;
  logic     full;
  logic     shift;
  logic     res_load;
  logic     res_acc;
  entry_t   res_entry;
  logic     cnt_inc, cnt_dec, head_adv, lvl_ld, k_ld, k_dec;
  slot_t    k_init;

  msjf_store u_store (
    .clk_i     (clk_i),
    .req_i     (mreq),
    .rd_data_o (rdata)
  );

  msjf_pick u_pick (
    .cnt_i   (cnt_q),
    .found_o (pick_found),
    .lvl_o   (pick_lvl)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (cnt_q[lvl_q] == CW'(DEPTH));
  assign shift    = (rdata.burst > new_q.burst);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (op_q == OP_TAKE) begin
          if (pick_found) state_d = S_TAKE;
          else if (out_free) state_d = S_IDLE;
        end else if (!lvl_ok_q || full || cnt_q[lvl_q] == '0) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (shift) begin
          if (k_q == slot_t'(1)) state_d = S_FIN;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_FIN, S_TAKE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mreq      = '0;
    res_load  = 1'b0;
    res_acc   = 1'b0;
    res_entry = '0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    head_adv  = 1'b0;
    lvl_ld    = 1'b0;
    k_ld      = 1'b0;
    k_dec     = 1'b0;
    k_init    = '0;
    case (state_q)
      S_START: begin
        if (op_q == OP_TAKE) begin
          if (pick_found) begin
            lvl_ld       = 1'b1;
            mreq.rd_en   = 1'b1;
            mreq.rd_lvl  = pick_lvl;
            mreq.rd_slot = head_q[pick_lvl];
          end else if (out_free) begin
            res_load = 1'b1;
          end
        end else if (!lvl_ok_q || full) begin
          res_load = out_free;
        end else if (cnt_q[lvl_q] == '0) begin
          if (out_free) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_lvl  = lvl_q;
            mreq.wr_slot = head_q[lvl_q];
            mreq.wdata   = new_q;
            res_load     = 1'b1;
            res_acc      = 1'b1;
            cnt_inc      = 1'b1;
          end
        end else begin
          // fetch the tail entry, the first one that may move up
          mreq.rd_en   = 1'b1;
          mreq.rd_lvl  = lvl_q;
          mreq.rd_slot = slot_add(head_q[lvl_q], PW'(cnt_q[lvl_q] - 1'b1));
          k_ld         = 1'b1;
          k_init       = PW'(cnt_q[lvl_q]);
        end
      end
      S_INS: begin
        if (shift) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_lvl  = lvl_q;
          mreq.wr_slot = slot_add(head_q[lvl_q], k_q);
          mreq.wdata   = rdata;
          k_dec        = 1'b1;
          if (k_q != slot_t'(1)) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_lvl  = lvl_q;
            mreq.rd_slot = slot_add(head_q[lvl_q], k_q - slot_t'(2));
          end
        end else if (out_free) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_lvl  = lvl_q;
          mreq.wr_slot = slot_add(head_q[lvl_q], k_q);
          mreq.wdata   = new_q;
          res_load     = 1'b1;
          res_acc      = 1'b1;
          cnt_inc      = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_lvl  = lvl_q;
          mreq.wr_slot = slot_add(head_q[lvl_q], k_q);
          mreq.wdata   = new_q;
          res_load     = 1'b1;
          res_acc      = 1'b1;
          cnt_inc      = 1'b1;
        end
      end
      S_TAKE: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_acc   = 1'b1;
          res_entry = rdata;
          head_adv  = 1'b1;
          cnt_dec   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        cnt_q[l]  <= '0;
        head_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cnt_inc) cnt_q[lvl_q] <= cnt_q[lvl_q] + 1'b1;
      if (cnt_dec) cnt_q[lvl_q] <= cnt_q[lvl_q] - 1'b1;
      if (head_adv) head_q[lvl_q] <= slot_inc(head_q[lvl_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= opcode_i[0];
      lvl_q    <= LW'(level_i);
      lvl_ok_q <= (32'(level_i) < LEVELS);
      new_q    <= '{id: job_id_i, burst: burst_i};
    end else if (lvl_ld) begin
      lvl_q <= pick_lvl;
    end
    if (k_ld) k_q <= k_init;
    else if (k_dec) k_q <= k_q - 1'b1;
    if (res_load) begin
      acc_q <= res_acc;
      sid_q <= res_entry.id;
      sb_q  <= res_entry.burst;
      slv_q <= (op_q == OP_TAKE && res_acc) ? 2'(lvl_q) : 2'd0;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign served_id_o    = sid_q;
  assign served_burst_o = sb_q;
  assign served_level_o = slv_q;

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result loaded over a pending one");

  a_ins_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (k_q != '0))
    else $error("insert walk reached position zero");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mreq.rd_en && mreq.wr_en && mreq.rd_lvl == mreq.wr_lvl &&
      mreq.rd_slot == mreq.wr_slot))
    else $error("read and write of the same entry in one cycle");

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAKE) |-> (cnt_q[lvl_q] != '0))
    else $error("take from an empty level");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_inc |-> (cnt_q[lvl_q] != CW'(DEPTH)))
    else $error("insert into a full level");

endmodule

// File: dv/multilevel_sjf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_sjf_checker: scoreboard for the multilevel SJF scheduler
// Keeps its own copy of the per-level queues, ordered by burst, and works
// out one outcome for each accepted request. Results are compared in order.
// ----------------------------------------------------------------------------
module multilevel_sjf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [0:0]  opcode_i,
  input  logic [1:0]  level_i,
  input  logic [7:0]  job_id_i,
  input  logic [15:0] burst_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        accepted_i,
  input  logic [7:0]  served_id_i,
  input  logic [15:0] served_burst_i,
  input  logic [1:0]  served_level_i,
  output int          fail_count_o,
  output int          outstanding_o
);
  import msjf_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  id;
    logic [15:0] burst;
    logic [1:0]  level;
  } outcome_t;

  entry_t   ready_jobs [LEVELS][DEPTH];
  int       ready_len  [LEVELS];
  outcome_t outcome_q  [$];
  int       fail_count;

  initial fail_count = 0;
  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, exp_val,
             got_val);
    fail_count++;
  endtask

  // Apply one request to the mirrored queues and return its outcome.
  function automatic outcome_t schedule_job(input logic op, input logic [1:0] lv,
                                            input logic [7:0] id, input logic [15:0] b);
    outcome_t res;
    int       n;
    int       pos;
    res = '0;
    if (op == OP_INSERT) begin
      if (int'(lv) >= LEVELS || ready_len[lv] >= DEPTH) begin
        return res;
      end
      n   = ready_len[lv];
      pos = 0;
      // equal bursts go behind the ones already waiting
      while (pos < n && ready_jobs[lv][pos].burst <= b) begin
        pos++;
      end
      for (int k = n; k > pos; k--) begin
        ready_jobs[lv][k] = ready_jobs[lv][k-1];
      end
      ready_jobs[lv][pos].id    = id;
      ready_jobs[lv][pos].burst = b;
      ready_len[lv]             = n + 1;
      res.accepted              = 1'b1;
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (ready_len[l] > 0) begin
          res.accepted = 1'b1;
          res.id       = ready_jobs[l][0].id;
          res.burst    = ready_jobs[l][0].burst;
          res.level    = 2'(l);
          for (int k = 0; k + 1 < ready_len[l]; k++) begin
            ready_jobs[l][k] = ready_jobs[l][k+1];
          end
          ready_len[l]--;
          return res;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_res;
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        ready_len[l] = 0;
      end
      outcome_q.delete();
      outstanding_o <= 0;
    end else begin
      // retire the result first: it always belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending", 0, 0);
        end else begin
          exp_res = outcome_q.pop_front();
          if (accepted_i !== exp_res.accepted) begin
            report_mismatch("accepted", 32'(exp_res.accepted), 32'(accepted_i));
          end
          if (served_id_i !== exp_res.id) begin
            report_mismatch("served_id", 32'(exp_res.id), 32'(served_id_i));
          end
          if (served_burst_i !== exp_res.burst) begin
            report_mismatch("served_burst", 32'(exp_res.burst), 32'(served_burst_i));
          end
          if (served_level_i !== exp_res.level) begin
            report_mismatch("served_level", 32'(exp_res.level), 32'(served_level_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        outcome_q.push_back(schedule_job(opcode_i[0], level_i, job_id_i, burst_i));
      end
      outstanding_o <= outcome_q.size();
    end
  end

endmodule

// File: dv/tb_multilevel_sjf_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multilevel_sjf_scheduler: testbench for the multilevel SJF scheduler
// Drives a directed set of inserts and takes, then random traffic in bursts
// with a stalling receiver; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_multilevel_sjf_scheduler;
  import msjf_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CHUNK        = 50;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [0:0]  opcode_i;
  logic [1:0]  level_i;
  logic [7:0]  job_id_i;
  logic [15:0] burst_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        accepted_o;
  logic [7:0]  served_id_o;
  logic [15:0] served_burst_o;
  logic [1:0]  served_level_o;
  int          fail_count;
  int          outstanding;

  multilevel_sjf_scheduler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .level_i        (level_i),
    .job_id_i       (job_id_i),
    .burst_i        (burst_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .served_id_o    (served_id_o),
    .served_burst_o (served_burst_o),
    .served_level_o (served_level_o)
  );

  multilevel_sjf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .opcode_i       (opcode_i),
    .level_i        (level_i),
    .job_id_i       (job_id_i),
    .burst_i        (burst_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_i     (accepted_o),
    .served_id_i    (served_id_o),
    .served_burst_i (served_burst_o),
    .served_level_i (served_level_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_INSERT;
    level_i     = '0;
    job_id_i    = '0;
    burst_i     = '0;
    out_ready_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: switch between stall styles, each held for a random stretch.
  ready_mode_e ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;
  int          ready_tick = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(3));
      mode_left  = $urandom_range(16, 96);
    end
    mode_left--;
    ready_tick++;
    case (ready_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_COIN:   out_ready_i <= 1'($urandom_range(1));
      RDY_SPARSE: out_ready_i <= ($urandom_range(3) == 0);
      default:    out_ready_i <= (ready_tick % 5 == 0);
    endcase
  end

  task automatic send_request(input logic op, input logic [1:0] lv, input logic [7:0] id,
                              input logic [15:0] b);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    level_i    <= lv;
    job_id_i   <= id;
    burst_i    <= b;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    int          burst_left;
    int          insert_pct;
    int          burst_span;
    int          bias_lvl;
    logic        op;
    logic [1:0]  lv;
    logic [15:0] b;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // nothing waiting, with every operand bit set
    send_request(OP_TAKE, 2'd3, 8'hFF, 16'hFFFF);
    // fill level 0: out-of-order bursts, a tie, and zero
    send_request(OP_INSERT, 2'd0, 8'h10, 16'd100);
    send_request(OP_INSERT, 2'd0, 8'h11, 16'd50);
    send_request(OP_INSERT, 2'd0, 8'h12, 16'd100);
    send_request(OP_INSERT, 2'd0, 8'h13, 16'd0);
    // level full
    send_request(OP_INSERT, 2'd0, 8'hFF, 16'hFFFF);
    send_request(OP_INSERT, 2'd3, 8'h00, 16'hFFFF);
    send_request(OP_INSERT, 2'd1, 8'hAA, 16'h5555);
    send_request(OP_INSERT, 2'd2, 8'h55, 16'hAAAA);
    // drain every level in priority order, then one more take on empty
    send_request(OP_TAKE, 2'd3, 8'h00, 16'h0000);
    send_request(OP_TAKE, 2'd2, 8'hFF, 16'hFFFF);
    send_request(OP_TAKE, 2'd1, 8'h5A, 16'hA5A5);
    send_request(OP_TAKE, 2'd0, 8'hA5, 16'h5A5A);
    send_request(OP_TAKE, 2'd3, 8'h01, 16'h0001);
    send_request(OP_TAKE, 2'd0, 8'h80, 16'h8000);
    send_request(OP_TAKE, 2'd1, 8'h7F, 16'h7FFF);
    send_request(OP_TAKE, 2'd2, 8'h00, 16'h0000);
    drain_results();

    burst_left = 0;
    insert_pct = 50;
    burst_span = 0;
    bias_lvl   = 4;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % CHUNK == 0) begin
        case ($urandom_range(3))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          2:       insert_pct = 60;
          default: insert_pct = 80;
        endcase
        case ($urandom_range(2))
          0:       burst_span = 7;
          1:       burst_span = 255;
          default: burst_span = 0;
        endcase
        bias_lvl = $urandom_range(4);
      end
      // let every pending result come out before going on
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (burst_left == 0) begin
        hold_off($urandom_range(1, 8));
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end
      burst_left--;
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_TAKE;
      lv = (bias_lvl < 4 && $urandom_range(1) == 1) ? 2'(bias_lvl) : 2'($urandom_range(3));
      b  = (burst_span == 0) ? 16'($urandom) : 16'($urandom_range(burst_span));
      send_request(op, lv, 8'($urandom_range(255)), b);
    end

    drain_results();
    repeat (DEPTH + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/msjf_pkg.sv
src/msjf_store.sv
src/msjf_pick.sv
src/multilevel_sjf_scheduler.sv
dv/multilevel_sjf_checker.sv
dv/tb_multilevel_sjf_scheduler.sv
